// File: hdl/ttsg_pkg.sv
`timescale 1ns / 1ps

package ttsg_pkg;

  // Input field widths
  localparam int ACTION_W  = 3;
  localparam int TEMP_IN_W = 19;
  localparam int TREND_W   = 2;
  localparam int SLOT_W    = 3;

  // Output field widths
  localparam int INST_RES_W = 3;
  localparam int TARGET_W   = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TRIPS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_INSTANCES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATCHET_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_HYSTERESIS = 3'd3;

  // Action codes as seen on the input port
  localparam logic [ACTION_W-1:0] ACT_EVALUATE  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_TRIP = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD_HYST = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ENTER     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RELEASE   = 3'd4;

  localparam logic [TREND_W-1:0] TREND_RISING  = 2'd1;
  localparam logic [TREND_W-1:0] TREND_FALLING = 2'd2;

  typedef enum logic [2:0] {
    OP_EVAL,
    OP_LOAD_TRIP,
    OP_LOAD_HYST,
    OP_ENTER,
    OP_RELEASE
  } op_t;

  // Classified item, as queued between front and back
  typedef struct packed {
    op_t                          op;
    logic                         do_scan;   // needs a trip table scan
    logic                         rise_scan; // rising scan, else falling scan
    logic signed [TEMP_IN_W-1:0]  temp;
    logic [SLOT_W-1:0]            slot;
    logic signed [TEMP_IN_W-1:0]  value;
  } item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] num_trips;
    logic [CFG_DATA_W-1:0] num_instances;
    logic                  ratchet;
    logic                  use_hyst;
  } cfg_t;

endpackage

// File: hdl/ttsg_front.sv
`timescale 1ns / 1ps

module ttsg_front (
  input  logic                                    start,
  input  logic                                    q_full,
  input  logic [ttsg_pkg::ACTION_W-1:0]           in_action,
  input  logic signed [ttsg_pkg::TEMP_IN_W-1:0]   in_temperature,
  input  logic [ttsg_pkg::TREND_W-1:0]            in_trend,
  input  logic [ttsg_pkg::SLOT_W-1:0]             in_trip_slot,
  input  logic signed [ttsg_pkg::TEMP_IN_W-1:0]   in_trip_value,
  output logic                                    push,
  output ttsg_pkg::item_t                         item
);

  logic known;
  logic rising;
  logic falling;

  assign rising  = (in_trend == ttsg_pkg::TREND_RISING);
  assign falling = (in_trend == ttsg_pkg::TREND_FALLING);

  always_comb begin
    known          = 1'b1;
    item.op        = ttsg_pkg::OP_EVAL;
    item.do_scan   = 1'b0;
    item.rise_scan = 1'b0;
    item.temp      = in_temperature;
    item.slot      = in_trip_slot;
    item.value     = in_trip_value;
    case (in_action)
      ttsg_pkg::ACT_EVALUATE: begin
        item.op        = ttsg_pkg::OP_EVAL;
        item.do_scan   = rising || falling;
        item.rise_scan = rising;
      end
      ttsg_pkg::ACT_LOAD_TRIP: item.op = ttsg_pkg::OP_LOAD_TRIP;
      ttsg_pkg::ACT_LOAD_HYST: item.op = ttsg_pkg::OP_LOAD_HYST;
      ttsg_pkg::ACT_ENTER: begin
        item.op      = ttsg_pkg::OP_ENTER;
        item.do_scan = 1'b1;
      end
      ttsg_pkg::ACT_RELEASE:   item.op = ttsg_pkg::OP_RELEASE;
      default:                 known   = 1'b0;
    endcase
  end

  // unknown actions are taken and dropped here
  assign push = start && !q_full && known;

endmodule

// File: hdl/ttsg_queue.sv
`timescale 1ns / 1ps

module ttsg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ttsg_pkg::item_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output ttsg_pkg::item_t head
);

  ttsg_pkg::item_t mem_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hdl/ttsg_back.sv
`timescale 1ns / 1ps

module ttsg_back #(
  parameter int MAX_TRIPS     = 8,
  parameter int MAX_INSTANCES = 8,
  parameter int TEMP_BITS     = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ttsg_pkg::cfg_t                      cfg,
  input  logic                                q_empty,
  input  ttsg_pkg::item_t                     q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  output logic [ttsg_pkg::INST_RES_W-1:0]     out_instance_res,
  output logic [ttsg_pkg::TARGET_W-1:0]       out_target_state,
  output logic                                out_changed,
  output logic                                out_last
);

  localparam int KW  = $clog2(MAX_TRIPS + 1);
  localparam int TIW = (MAX_TRIPS > 1) ? $clog2(MAX_TRIPS) : 1;
  localparam int NW  = $clog2(MAX_INSTANCES + 1);
  localparam int IW  = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
  localparam int TIN = ttsg_pkg::TEMP_IN_W;
  // compare width, always wider than both operands
  localparam int CW  = ((TEMP_BITS > TIN) ? TEMP_BITS : TIN) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                         state_r;
  ttsg_pkg::item_t                cur_r;
  logic [KW-1:0]                  k_r;
  logic [KW-1:0]                  cand_r;
  logic [IW-1:0]                  j_r;
  logic [MAX_INSTANCES-1:0]       tvalid_r;
  logic [KW-1:0]                  target_r [MAX_INSTANCES];
  logic [TEMP_BITS-1:0]           trip_mem [MAX_TRIPS];
  logic [TEMP_BITS-1:0]           hyst_mem [MAX_TRIPS];

  logic                           out_valid_r;
  logic [ttsg_pkg::INST_RES_W-1:0] out_inst_r;
  logic [ttsg_pkg::TARGET_W-1:0]  out_target_r;
  logic                           out_changed_r;
  logic                           out_last_r;

  logic [KW-1:0]                  n_trips;
  logic [NW-1:0]                  n_inst;
  logic [TEMP_BITS-1:0]           entry;
  logic signed [CW-1:0]           t_x;
  logic signed [CW-1:0]           e_x;
  logic signed [CW-1:0]           v_x;
  logic                           hit;
  logic                           scan_end;
  logic [KW-1:0]                  old_raw;
  logic                           was_valid;
  logic [KW-1:0]                  old_t;
  logic [KW-1:0]                  newt;
  logic                           chg;
  logic                           is_last;
  logic                           is_load;
  logic                           slot_ok;

  assign n_trips = ({28'd0, cfg.num_trips} > 32'(MAX_TRIPS)) ? KW'(MAX_TRIPS)
                                                              : KW'(cfg.num_trips);
  assign n_inst  = ({28'd0, cfg.num_instances} > 32'(MAX_INSTANCES)) ? NW'(MAX_INSTANCES)
                                                                      : NW'(cfg.num_instances);

  // one table entry compared per scan cycle
  assign entry = (cfg.use_hyst && !cur_r.rise_scan) ? hyst_mem[k_r[TIW-1:0]]
                                                    : trip_mem[k_r[TIW-1:0]];
  assign t_x   = {{(CW - TIN){cur_r.temp[TIN-1]}}, cur_r.temp};
  assign e_x   = {{(CW - TEMP_BITS){entry[TEMP_BITS-1]}}, entry};
  assign hit   = cur_r.rise_scan ? (t_x < e_x) : (t_x <= e_x);
  assign scan_end = (k_r >= n_trips) || hit;

  assign v_x     = {{(CW - TIN){q_head.value[TIN-1]}}, q_head.value};
  assign is_load = (q_head.op == ttsg_pkg::OP_LOAD_TRIP) ||
                   (q_head.op == ttsg_pkg::OP_LOAD_HYST);
  assign slot_ok = (32'(q_head.slot) < MAX_TRIPS);
  assign q_pop   = (state_r == S_IDLE) && !q_empty;

  assign old_raw   = target_r[j_r];
  assign was_valid = tvalid_r[j_r];
  assign old_t     = was_valid ? old_raw : '0;
  assign is_last   = (NW'(j_r) == n_inst - NW'(1));

  always_comb begin
    newt = old_t;
    chg  = 1'b0;
    case (cur_r.op)
      ttsg_pkg::OP_EVAL: begin
        if (cur_r.do_scan) begin
          if (!cfg.ratchet) begin
            newt = cand_r;
          end else if (cur_r.rise_scan) begin
            newt = (cand_r > old_t) ? cand_r : old_t;
          end else begin
            newt = (cand_r < old_t) ? cand_r : old_t;
          end
        end
        chg = !was_valid || (newt != old_raw);
      end
      ttsg_pkg::OP_ENTER: begin
        newt = cand_r;
        chg  = 1'b1;
      end
      ttsg_pkg::OP_RELEASE: begin
        newt = '0;
        chg  = 1'b1;
      end
      default: begin
        newt = old_t;
        chg  = 1'b0;
      end
    endcase
  end

  // table stores: no reset, unwritten entries are don't-care
  always_ff @(posedge clk) begin
    if (q_pop && is_load && slot_ok) begin
      if (q_head.op == ttsg_pkg::OP_LOAD_TRIP) begin
        trip_mem[TIW'(q_head.slot)] <= v_x[TEMP_BITS-1:0];
      end else begin
        hyst_mem[TIW'(q_head.slot)] <= v_x[TEMP_BITS-1:0];
      end
    end
    if (state_r == S_EMIT) begin
      target_r[j_r] <= newt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tvalid_r    <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cur_r <= q_head;
            k_r   <= '0;
            j_r   <= '0;
            if (is_load || n_inst == '0) begin
              state_r <= S_IDLE;
            end else if (q_head.do_scan) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            cand_r  <= k_r;
            state_r <= S_EMIT;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_EMIT: begin
          out_valid_r   <= 1'b1;
          out_inst_r    <= ttsg_pkg::INST_RES_W'(j_r);
          out_target_r  <= ttsg_pkg::TARGET_W'(newt);
          out_changed_r <= chg;
          out_last_r    <= is_last;
          tvalid_r[j_r] <= 1'b1;
          if (is_last) begin
            state_r <= S_IDLE;
          end else begin
            j_r <= j_r + IW'(1);
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_instance_res = out_inst_r;
  assign out_target_state = out_target_r;
  assign out_changed      = out_changed_r;
  assign out_last         = out_last_r;

endmodule

// File: hdl/thermal_trip_state_governor.sv
`timescale 1ns / 1ps
// Thermal trip governor with hysteresis and per-instance cooling targets.
//
// Input: an item is transferred on a clock edge with start high and busy low.
// Actions: evaluate, load trip entry, load hysteresis entry, enter kernel
// control, release. Loads and unknown actions produce no results; the other
// actions produce one result per cooling instance, instance 0 first, on
// consecutive cycles, each marked by out_valid for a single cycle and
// out_last on the final one. The receiver has no way to hold results off.
// Configuration: cfg_valid/cfg_ready write channel (cfg_ready is always
// high), cfg_index selects num_trips, num_instances, ratchet_mode,
// use_hysteresis. Write it only while no item is in flight.
// Flow: the front classifies an item into a two-entry queue; busy rises
// only when that queue is full. The back engine picks an item from the
// queue, then scans trip entries one per cycle (evaluate with rising/falling
// trend and enter only), then emits one result per cycle, one per instance.
// It picks no new item until the last result of the current one is out.
// Reset: configuration returns to 0/1/0/0, all targets read as unset, the
// queue empties. Trip and hysteresis tables hold garbage until loaded.

module thermal_trip_state_governor #(
  parameter int MAX_TRIPS     = 8,
  parameter int MAX_INSTANCES = 8,
  parameter int TEMP_BITS     = 20
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [ttsg_pkg::ACTION_W-1:0]           in_action,
  input  logic signed [ttsg_pkg::TEMP_IN_W-1:0]   in_temperature,
  input  logic [ttsg_pkg::TREND_W-1:0]            in_trend,
  input  logic [ttsg_pkg::SLOT_W-1:0]             in_trip_slot,
  input  logic signed [ttsg_pkg::TEMP_IN_W-1:0]   in_trip_value,
  output logic                                    out_valid,
  output logic [ttsg_pkg::INST_RES_W-1:0]         out_instance_res,
  output logic [ttsg_pkg::TARGET_W-1:0]           out_target_state,
  output logic                                    out_changed,
  output logic                                    out_last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [ttsg_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ttsg_pkg::CFG_DATA_W-1:0]         cfg_data
);

  ttsg_pkg::cfg_t  cfg_r;
  logic            q_full;
  logic            q_empty;
  logic            q_push;
  logic            q_pop;
  ttsg_pkg::item_t f_item;
  ttsg_pkg::item_t q_head;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_trips     <= '0;
      cfg_r.num_instances <= ttsg_pkg::CFG_DATA_W'(1);
      cfg_r.ratchet       <= 1'b0;
      cfg_r.use_hyst      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ttsg_pkg::CFG_NUM_TRIPS:      cfg_r.num_trips     <= cfg_data;
        ttsg_pkg::CFG_NUM_INSTANCES:  cfg_r.num_instances <= cfg_data;
        ttsg_pkg::CFG_RATCHET_MODE:   cfg_r.ratchet       <= cfg_data[0];
        ttsg_pkg::CFG_USE_HYSTERESIS: cfg_r.use_hyst      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ttsg_front u_front (
    .start          (start),
    .q_full         (q_full),
    .in_action      (in_action),
    .in_temperature (in_temperature),
    .in_trend       (in_trend),
    .in_trip_slot   (in_trip_slot),
    .in_trip_value  (in_trip_value),
    .push           (q_push),
    .item           (f_item)
  );

  ttsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (f_item),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  ttsg_back #(
    .MAX_TRIPS     (MAX_TRIPS),
    .MAX_INSTANCES (MAX_INSTANCES),
    .TEMP_BITS     (TEMP_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_instance_res (out_instance_res),
    .out_target_state (out_target_state),
    .out_changed      (out_changed),
    .out_last         (out_last)
  );

endmodule

// File: hdl/ttsg_checker.sv
`timescale 1ns / 1ps

module ttsg_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_last,
  input logic [ttsg_pkg::INST_RES_W-1:0]     out_instance_res
);

  // last only ever marks a real result
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  // a run of results is unbroken until its last one
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a result run");

  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=>
      out_instance_res == ($past(out_instance_res) + ttsg_pkg::INST_RES_W'(1)))
    else $error("instance index out of order");

  // engine goes back to pick the next item after a run
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after end of run");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_instance_res == '0)
    else $error("run does not start at instance 0");

endmodule

bind thermal_trip_state_governor ttsg_checker u_ttsg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_last         (out_last),
  .out_instance_res (out_instance_res)
);
